FILE: hdl/spectral_peak_picker_top_assert.svh
// Assertion macros shared by the spectral peak picker RTL.
`ifndef SPECTRAL_PEAK_PICKER_TOP_ASSERT_SVH
`define SPECTRAL_PEAK_PICKER_TOP_ASSERT_SVH

// same-cycle implication
`define SPP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define SPP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: hdl/spp_pkg.sv
// Types and constants of the spectral peak picker.
package spp_pkg;

    localparam int SUM_W  = 32;
    localparam int CH_W   = 31;
    localparam int POS_W  = 18;
    localparam int PWR_W  = 64;
    localparam int SHR_W  = 17;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [SUM_W-1:0] ym;
        logic [SUM_W-1:0] y0;
        logic [SUM_W-1:0] y1;
        logic [CH_W-1:0]  l0;
        logic [CH_W-1:0]  l1;
        logic [CH_W-1:0]  l2;
        logic [CH_W-1:0]  r0;
        logic [CH_W-1:0]  r1;
        logic [CH_W-1:0]  r2;
        logic [POS_W-1:0] base;
    } t_peak;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_SQA,
        ST_SQB,
        ST_PREP,
        ST_INTERP,
        ST_NORM,
        ST_SHARE,
        ST_DONE
    } t_back_state;

endpackage

FILE: hdl/spp_front.sv
// Front end: threshold, three-bin window, local maximum detection.
module spp_front import spp_pkg::*; #(
    parameter int BINS      = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_push,
    input  logic [CH_W-1:0]  i_l_power,
    input  logic [CH_W-1:0]  i_r_power,
    input  logic             i_last_bin,
    input  t_q_status        i_q_status,
    output logic             o_pk_valid,
    output t_peak            o_pk
);

    localparam int BW = $clog2(BINS);
    localparam int PW = (BW + FRAC_BITS > POS_W) ? BW + FRAC_BITS : POS_W;

    logic [31:0]      r_thr;
    logic [BW-1:0]    r_cnt;
    logic [SUM_W-1:0] r_s1, r_s2;
    logic [CH_W-1:0]  r_l1, r_l2, r_r1, r_r2;

    logic             accept, peak, last;
    logic [SUM_W-1:0] sum, sum_t;
    logic [BW-1:0]    k;
    logic [PW-1:0]    k_shift;

    assign accept  = i_push && !i_q_status.full;
    assign sum     = SUM_W'({1'b0, i_l_power}) + SUM_W'({1'b0, i_r_power});
    assign sum_t   = (sum < r_thr) ? '0 : sum;
    assign peak    = (r_cnt >= BW'(2)) && (r_s2 > r_s1) && (r_s2 > sum_t);
    assign last    = i_last_bin || (r_cnt == BW'(BINS - 1));
    assign k       = r_cnt - BW'(1);
    assign k_shift = PW'(k) << FRAC_BITS;

    assign o_pk_valid = accept && peak;
    always_comb begin
        o_pk.ym   = r_s1;
        o_pk.y0   = r_s2;
        o_pk.y1   = sum_t;
        o_pk.l0   = r_l1;
        o_pk.l1   = r_l2;
        o_pk.l2   = i_l_power;
        o_pk.r0   = r_r1;
        o_pk.r1   = r_r2;
        o_pk.r2   = i_r_power;
        o_pk.base = k_shift[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
            r_l1  <= '0;
            r_l2  <= '0;
            r_r1  <= '0;
            r_r2  <= '0;
        end else if (accept) begin
            if (last) begin
                r_cnt <= '0;
                r_s1  <= '0;
                r_s2  <= '0;
                r_l1  <= '0;
                r_l2  <= '0;
                r_r1  <= '0;
                r_r2  <= '0;
            end else begin
                r_cnt <= r_cnt + BW'(1);
                r_s1  <= r_s2;
                r_s2  <= sum_t;
                r_l1  <= r_l2;
                r_l2  <= i_l_power;
                r_r1  <= r_r2;
                r_r2  <= i_r_power;
            end
        end
    end

endmodule

FILE: hdl/spp_queue.sv
// Short queue of peak descriptors between front and back.
module spp_queue import spp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_peak     i_data,
    input  logic      i_pop,
    output t_peak     o_data,
    output t_q_status o_status
);

`include "spectral_peak_picker_top_assert.svh"

    t_peak             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              push_ok, pop_ok;

    assign o_status.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign push_ok = i_push && !o_status.full;
    assign pop_ok  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

    `SPP_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (QPTR_W+1)'(QDEPTH))
    `SPP_ASSERT_IMP(a_empty_ptr, i_clk, i_rst_n, r_cnt == '0, r_wr == r_rd)
    `SPP_ASSERT_NXT(a_fill, i_clk, i_rst_n, push_ok && !pop_ok, r_cnt == $past(r_cnt) + 1'b1)

endmodule

FILE: hdl/spp_back.sv
// Back end: interpolation of one peak at a time and the result register.
module spp_back import spp_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_peak             i_pk,
    input  t_q_status         i_q_status,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [POS_W-1:0]  o_peak_position,
    output logic [PWR_W-1:0]  o_peak_power,
    output logic [SHR_W-1:0]  o_stereo_share
);

`include "spectral_peak_picker_top_assert.svh"

    localparam int F  = FRAC_BITS;
    localparam int DW = 36;
    localparam int AW = PWR_W + F;
    localparam int LW = CH_W + F;
    localparam int TW = CH_W + 1 + F;
    localparam int RW = TW + 1;

    t_back_state r_state, n_state;

    t_peak             r_pk;
    logic              r_neg;
    logic [DW-1:0]     r_rem, r_den;
    logic [F-1:0]      r_q, r_part;
    logic [4:0]        r_cnt;
    logic [POS_W-1:0]  r_pos;
    logic [SUM_W-1:0]  r_b;
    logic [CH_W-1:0]   r_la, r_lb, r_ra, r_rb;
    logic [PWR_W-1:0]  r_sa, r_sb;
    logic [AW-1:0]     r_acc_sq, r_d_sq;
    logic [LW-1:0]     r_acc_l, r_acc_r, r_d_l, r_d_r;
    logic [TW-1:0]     r_tot;
    logic [RW-1:0]     r_rem2;
    logic [SHR_W-1:0]  r_shr;
    logic              r_ov;

    logic              out_load;
    logic [SUM_W-1:0]  diff;
    logic              neg;
    logic [34:0]       den_half;
    logic [DW-1:0]     rem_sh;
    logic              div_ge;
    logic [F-1:0]      qm, part;
    logic              lo0;
    logic [SUM_W-1:0]  sel_a, sel_b, mul_op;
    logic [PWR_W-1:0]  mul_res;
    logic [PWR_W:0]    dsq;
    logic [CH_W:0]     dl, dr;
    logic [RW-1:0]     rem2_s, tot_ext;
    logic              shr_ge;

    // setup values
    assign neg      = i_pk.ym > i_pk.y1;
    assign diff     = r_neg ? (r_pk.ym - r_pk.y1) : (r_pk.y1 - r_pk.ym);
    assign den_half = {2'b00, r_pk.y0, 1'b0} - {3'b000, r_pk.ym} - {3'b000, r_pk.y1};

    assign rem_sh = {r_rem[DW-2:0], 1'b0};
    assign div_ge = rem_sh >= r_den;

    // rounded quotient and interpolation side
    assign qm    = r_q + F'(r_neg && (r_rem != '0));
    assign lo0   = r_neg && (qm != '0);
    assign part  = lo0 ? (~qm + F'(1)) : qm;
    assign sel_a = lo0 ? r_pk.ym : r_pk.y0;
    assign sel_b = lo0 ? r_pk.y0 : r_pk.y1;

    assign mul_op  = (r_state == ST_SQA) ? sel_a : r_b;
    assign mul_res = PWR_W'(mul_op) * PWR_W'(mul_op);

    assign dsq = {1'b0, r_sb} - {1'b0, r_sa};
    assign dl  = {1'b0, r_lb} - {1'b0, r_la};
    assign dr  = {1'b0, r_rb} - {1'b0, r_ra};

    assign tot_ext = RW'(r_tot);
    assign rem2_s  = (r_cnt == '0) ? r_rem2 : {r_rem2[RW-2:0], 1'b0};
    assign shr_ge  = rem2_s >= tot_ext;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (!i_q_status.empty) n_state = ST_SETUP;
            ST_SETUP:  n_state = ST_DIV;
            ST_DIV:    if (r_cnt == 5'(F - 1)) n_state = ST_SQA;
            ST_SQA:    n_state = ST_SQB;
            ST_SQB:    n_state = ST_PREP;
            ST_PREP:   n_state = ST_INTERP;
            ST_INTERP: if (r_cnt == 5'(F - 1)) n_state = ST_NORM;
            ST_NORM:   n_state = ST_SHARE;
            ST_SHARE:  if (r_cnt == 5'(SHR_W - 1)) n_state = ST_DONE;
            ST_DONE:   if (!r_ov || i_pop) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop  = (r_state == ST_IDLE) && !i_q_status.empty;
        out_load = (r_state == ST_DONE) && (!r_ov || i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_pk  <= i_pk;
                r_neg <= neg;
            end
            ST_SETUP: begin
                r_rem <= DW'(diff);
                r_den <= {den_half, 1'b0};
                r_q   <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= div_ge ? (rem_sh - r_den) : rem_sh;
                r_q   <= {r_q[F-2:0], div_ge};
                r_cnt <= r_cnt + 5'(1);
            end
            ST_SQA: begin
                r_part <= part;
                r_pos  <= r_neg ? (r_pk.base - POS_W'(qm)) : (r_pk.base + POS_W'(qm));
                r_sa   <= mul_res;
                r_b    <= sel_b;
                r_la   <= lo0 ? r_pk.l0 : r_pk.l1;
                r_lb   <= lo0 ? r_pk.l1 : r_pk.l2;
                r_ra   <= lo0 ? r_pk.r0 : r_pk.r1;
                r_rb   <= lo0 ? r_pk.r1 : r_pk.r2;
            end
            ST_SQB: begin
                r_sb <= mul_res;
            end
            ST_PREP: begin
                r_acc_sq <= {r_sa, F'(0)};
                r_d_sq   <= {{(AW-PWR_W-1){dsq[PWR_W]}}, dsq};
                r_acc_l  <= {r_la, F'(0)};
                r_acc_r  <= {r_ra, F'(0)};
                r_d_l    <= {{(LW-CH_W-1){dl[CH_W]}}, dl};
                r_d_r    <= {{(LW-CH_W-1){dr[CH_W]}}, dr};
                r_cnt    <= '0;
            end
            ST_INTERP: begin
                if (r_part[0]) begin
                    r_acc_sq <= r_acc_sq + r_d_sq;
                    r_acc_l  <= r_acc_l + r_d_l;
                    r_acc_r  <= r_acc_r + r_d_r;
                end
                r_part <= r_part >> 1;
                r_d_sq <= r_d_sq << 1;
                r_d_l  <= r_d_l << 1;
                r_d_r  <= r_d_r << 1;
                r_cnt  <= r_cnt + 5'(1);
            end
            ST_NORM: begin
                r_tot  <= TW'(r_acc_l) + TW'(r_acc_r);
                r_rem2 <= RW'(r_acc_l);
                r_shr  <= '0;
                r_cnt  <= '0;
            end
            ST_SHARE: begin
                r_rem2 <= shr_ge ? (rem2_s - tot_ext) : rem2_s;
                r_shr  <= {r_shr[SHR_W-2:0], shr_ge};
                r_cnt  <= r_cnt + 5'(1);
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_peak_position <= r_pos;
            o_peak_power    <= r_acc_sq[AW-1:F];
            o_stereo_share  <= (r_tot == '0) ? '0 : r_shr;
        end
    end

    assign o_empty = !r_ov;

    `SPP_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_state == ST_IDLE)
    `SPP_ASSERT_IMP(a_load_free, i_clk, i_rst_n, out_load && r_ov, i_pop)

endmodule

FILE: hdl/spectral_peak_picker_top.sv
// Top level of the spectral peak picker.
// Bins enter through a queue-style port and are taken one per cycle while full is
// low; a strict local maximum of the thresholded left+right power (from bin 1, window
// cleared after a last bin or bin BINS-1) yields one result: interpolated position
// with FRAC_BITS fraction bits, interpolated squared power and left share in 16
// fraction bits. Each peak in turn occupies the shared back-end unit (a bit-serial
// divider, a squaring multiplier, a bit-serial interpolator and a 17-step share
// divider); a 4-entry queue holds peaks found meanwhile, and full is raised while
// it is full. Results wait in an output register until popped.
module spectral_peak_picker_top import spp_pkg::*; #(
    parameter int BINS      = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [CH_W-1:0]   i_l_power,
    input  logic [CH_W-1:0]   i_r_power,
    input  logic              i_last_bin,
    output logic              empty,
    input  logic              pop,
    output logic [POS_W-1:0]  o_peak_position,
    output logic [PWR_W-1:0]  o_peak_power,
    output logic [SHR_W-1:0]  o_stereo_share
);

    t_q_status q_status;
    t_peak     pk_in, pk_out;
    logic      pk_valid, q_pop;

    assign full = q_status.full;

    spp_front #(.BINS(BINS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_l_power  (i_l_power),
        .i_r_power  (i_r_power),
        .i_last_bin (i_last_bin),
        .i_q_status (q_status),
        .o_pk_valid (pk_valid),
        .o_pk       (pk_in)
    );

    spp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (pk_valid),
        .i_data   (pk_in),
        .i_pop    (q_pop),
        .o_data   (pk_out),
        .o_status (q_status)
    );

    spp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pk            (pk_out),
        .i_q_status      (q_status),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_peak_position (o_peak_position),
        .o_peak_power    (o_peak_power),
        .o_stereo_share  (o_stereo_share)
    );

endmodule

FILE: verif/spp_checker.sv
// Scoreboard for the spectral peak picker: predicts peaks per accepted bin and checks pops.
module spp_checker import spp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_data,
    input  logic             push,
    input  logic             full,
    input  logic [CH_W-1:0]  i_l_power,
    input  logic [CH_W-1:0]  i_r_power,
    input  logic             i_last_bin,
    input  logic             empty,
    input  logic             pop,
    input  logic [POS_W-1:0] o_peak_position,
    input  logic [PWR_W-1:0] o_peak_power,
    input  logic [SHR_W-1:0] o_stereo_share,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS = 1024;
    localparam int FRAC = 8;
    localparam logic [63:0] ONE = 64'd1 << FRAC;

    typedef struct {
        logic [POS_W-1:0] position;
        logic [PWR_W-1:0] power;
        logic [SHR_W-1:0] share;
    } t_peak_result;

    t_peak_result peak_q[$];
    logic [31:0] threshold;
    logic [63:0] sum_win[3];
    logic [63:0] left_win[3];
    logic [63:0] right_win[3];
    int unsigned bin_idx;

    assign o_pending = peak_q.size();

    function automatic logic [63:0] interp_sq(logic [63:0] a, logic [63:0] b, logic [63:0] part);
        logic [63:0] sa, sb, w, hi, lo;
        sa = a * a;
        sb = b * b;
        w  = ONE - part;
        hi = w * (sa >> FRAC) + part * (sb >> FRAC);
        lo = w * (sa & (ONE - 1)) + part * (sb & (ONE - 1));
        return hi + (lo >> FRAC);
    endfunction

    // shifts one bin into the window; returns 1 with a predicted peak when found
    function automatic bit take_bin(logic [63:0] l, logic [63:0] r, bit last,
                                    output t_peak_result res);
        logic [63:0] s, ym, y0, y1, den2, mag, part, lnum, rnum, tot;
        longint q, pos;
        int lo_idx;
        bit found;
        found = 0;
        s = l + r;
        if (s < {32'd0, threshold}) s = 0;
        sum_win[0] = sum_win[1];     sum_win[1] = sum_win[2];     sum_win[2] = s;
        left_win[0] = left_win[1];   left_win[1] = left_win[2];   left_win[2] = l;
        right_win[0] = right_win[1]; right_win[1] = right_win[2]; right_win[2] = r;
        if (bin_idx >= 2 && sum_win[1] > sum_win[0] && sum_win[1] > sum_win[2]) begin
            ym = sum_win[0];
            y0 = sum_win[1];
            y1 = sum_win[2];
            den2 = 2 * (2 * y0 - ym - y1);
            if (ym > y1) begin
                mag = (ym - y1) << FRAC;
                q = -longint'((mag + den2 - 1) / den2);
            end else begin
                mag = (y1 - ym) << FRAC;
                q = longint'(mag / den2);
            end
            if (q < 0) begin
                lo_idx = 0;
                part = 64'(q + longint'(ONE));
            end else begin
                lo_idx = 1;
                part = 64'(q);
            end
            pos = (longint'(bin_idx - 1) << FRAC) + q;
            lnum = (ONE - part) * left_win[lo_idx] + part * left_win[lo_idx + 1];
            rnum = (ONE - part) * right_win[lo_idx] + part * right_win[lo_idx + 1];
            tot = lnum + rnum;
            res.position = POS_W'(pos);
            res.power = interp_sq(sum_win[lo_idx], sum_win[lo_idx + 1], part);
            res.share = (tot == 0) ? '0 : SHR_W'((lnum << 16) / tot);
            found = 1;
        end
        if (last || bin_idx >= BINS - 1) begin
            for (int k = 0; k < 3; k++) begin
                sum_win[k] = 0;
                left_win[k] = 0;
                right_win[k] = 0;
            end
            bin_idx = 0;
        end else begin
            bin_idx++;
        end
        return found;
    endfunction

    always @(posedge i_clk) begin
        t_peak_result res, exp_r;
        if (!i_rst_n) begin
            threshold <= '0;
            for (int k = 0; k < 3; k++) begin
                sum_win[k] = 0;
                left_win[k] = 0;
                right_win[k] = 0;
            end
            bin_idx = 0;
            peak_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) threshold <= i_cfg_data;
            if (push && !full) begin
                if (take_bin(64'(i_l_power), 64'(i_r_power), i_last_bin, res))
                    peak_q = {peak_q, res};
            end
            if (pop && !empty) begin
                if (peak_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected peak transfer: pos %h pwr %h share %h",
                                 o_peak_position, o_peak_power, o_stereo_share);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = peak_q.pop_front();
                    if (exp_r.position !== o_peak_position || exp_r.power !== o_peak_power
                            || exp_r.share !== o_stereo_share) begin
                        if (o_errors < 10)
                            $display("peak mismatch: exp pos %h pwr %h share %h, got %h %h %h",
                                     exp_r.position, exp_r.power, exp_r.share,
                                     o_peak_position, o_peak_power, o_stereo_share);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/spectral_peak_picker_top_tb.sv
// Testbench top: drives bins and threshold settings into the peak picker and gives the verdict.
module spectral_peak_picker_top_tb;
    import spp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CH_W-1:0] CH_MAX = '1;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [31:0] i_cfg_data = '0;
    logic push = 0;
    logic full, empty;
    logic pop = 0;
    logic [CH_W-1:0] i_l_power = '0;
    logic [CH_W-1:0] i_r_power = '0;
    logic i_last_bin = 0;
    logic [POS_W-1:0] o_peak_position;
    logic [PWR_W-1:0] o_peak_power;
    logic [SHR_W-1:0] o_stereo_share;
    int errors, pending;
    int send_idle = 0;
    int rx_stall = 0;
    logic hold_req = 0;
    int hold_cnt = 0;
    int quiet = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    spectral_peak_picker_top dut (.*);

    spp_checker chk (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 0;
            hold_cnt <= 0;
        end else if (hold_req) begin
            pop <= 0;
            hold_cnt <= 400;
        end else if (hold_cnt > 0) begin
            pop <= 0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            pop <= ($urandom_range(99) >= rx_stall);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("spectral_peak_picker_top_tb: done, errors");
            $finish;
        end
    end

    task automatic send_bin(logic [CH_W-1:0] l, logic [CH_W-1:0] r, bit last);
        while ($urandom_range(99) < send_idle) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_l_power <= l;
        i_r_power <= r;
        i_last_bin <= last;
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [31:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [CH_W-1:0] rand_power();
        case ($urandom_range(7))
            0: return '0;
            1: return CH_MAX;
            2, 3: return CH_W'($urandom());
            4: return CH_W'($urandom_range(65535));
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    task automatic rand_frames(int n);
        int len;
        for (int i = 0; i < n; ) begin
            len = $urandom_range(1, 12);
            for (int b = 0; b < len; b++) begin
                if ($urandom_range(19) == 0) send_bin(rand_power(), rand_power(), $urandom_range(1));
                else send_bin(rand_power(), rand_power(), b == len - 1);
                i++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_bin(0, 0, 0);
        send_bin(3, 2, 0);
        send_bin(0, 0, 1);
        send_bin(1, 0, 0);
        send_bin(CH_MAX, CH_MAX, 0);
        send_bin(CH_MAX, 0, 0);
        send_bin(0, CH_MAX, 0);
        send_bin(0, 0, 1);
        send_bin(5, 5, 0);
        send_bin(5, 5, 0);
        send_bin(9, 0, 0);
        send_bin(4, 4, 0);
        send_bin(4, 0, 1);
        send_bin(7, 7, 1);
        set_threshold(32'hFFFF_FFFE);
        send_bin(CH_MAX, CH_MAX - 1, 0);
        send_bin(CH_MAX, CH_MAX, 0);
        send_bin(0, CH_MAX, 1);
        set_threshold(32'd100);
        send_bin(30, 30, 0);
        send_bin(60, 60, 0);
        send_bin(90, 9, 1);

        set_threshold(0);
        rand_frames(15);
        send_idle = 60;
        set_threshold($urandom());
        rand_frames(15);
        send_idle = 0;
        rx_stall = 60;
        set_threshold($urandom_range(1000));
        rand_frames(15);
        send_idle = 7;
        rx_stall = 7;
        set_threshold(32'hFFFF_FFFE);
        rand_frames(10);
        set_threshold(0);
        hold_req <= 1;
        @(posedge i_clk);
        hold_req <= 0;
        send_idle = 0;
        for (int i = 0; i < 40; i++) send_bin(i % 2 ? 0 : rand_power(), rand_power(), 0);
        drain();
        // overlong frame without a last bin
        for (int i = 0; i < 1026; i++) begin
            if (i % 90 == 0) begin
                send_idle = 0;
                rx_stall = (i % 180 == 0) ? 0 : 60;
            end
            send_bin(rand_power(), rand_power(), 0);
        end
        rx_stall = 0;

        drain();
        if (errors == 0 && pending == 0) begin
            $display("spectral_peak_picker_top_tb: done, clean");
        end else begin
            $display("spectral_peak_picker_top_tb: done, errors");
        end
        $finish;
    end
endmodule
